/* rtl/counter_priority_task_scheduler_assert.svh */
// assertion macros for the counter priority task scheduler
// no dependencies; included by files that carry concurrent checks
`ifndef COUNTER_PRIORITY_TASK_SCHEDULER_ASSERT_SVH
`define COUNTER_PRIORITY_TASK_SCHEDULER_ASSERT_SVH
`ifndef ASSERT_OFF
// same-cycle implication
`define CPS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define CPS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define CPS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define CPS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

/* rtl/cps_pkg.sv */
`timescale 1ns / 1ps
// types, codes and constants shared by the task scheduler
// no dependencies
package cps_pkg;

  // field widths
  localparam int unsigned OP_W    = 2;
  localparam int unsigned SLOT_W  = 6;
  localparam int unsigned STATE_W = 3;
  localparam int unsigned CNT_W   = 9;
  localparam int unsigned PRIO_W  = 8;
  localparam int unsigned ALARM_W = 31;
  localparam int unsigned SIG_W   = 32;

  localparam int unsigned NUM_TASKS_DEF = 64;

  // op codes
  localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
  localparam logic [OP_W-1:0] OP_SCHED = 2'd1;
  localparam logic [OP_W-1:0] OP_READ  = 2'd2;

  // run state codes
  localparam logic [STATE_W-1:0] RS_RUNNING       = 3'd0;
  localparam logic [STATE_W-1:0] RS_INTERRUPTIBLE = 3'd1;

  // signal bits: bit n-1 for signal n
  localparam logic [SIG_W-1:0] SIG_KILL_BIT = 32'h0000_0100;
  localparam logic [SIG_W-1:0] SIG_ALRM_BIT = 32'h0000_2000;
  localparam logic [SIG_W-1:0] SIG_STOP_BIT = 32'h0004_0000;
  localparam logic [SIG_W-1:0] BLOCKABLE_MASK = ~(SIG_KILL_BIT | SIG_STOP_BIT);

  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [SLOT_W-1:0]  slot;
    logic               present;
    logic [STATE_W-1:0] run_state;
    logic [CNT_W-1:0]   counter;
    logic [PRIO_W-1:0]  priority_req;
    logic [ALARM_W-1:0] alarm_time;
    logic [SIG_W-1:0]   signals;
    logic [SIG_W-1:0]   blocked_mask;
    logic [ALARM_W-1:0] now_time;
  } in_item_t;

  typedef struct packed {
    logic [SLOT_W-1:0]  next_task;
    logic               recharged;
    logic               entry_present;
    logic [STATE_W-1:0] entry_state;
    logic [CNT_W-1:0]   entry_counter;
    logic [SIG_W-1:0]   entry_signals;
    logic [ALARM_W-1:0] entry_alarm;
  } out_item_t;

  // one task slot
  typedef struct packed {
    logic               present;
    logic [STATE_W-1:0] run_state;
    logic [CNT_W-1:0]   counter;
    logic [PRIO_W-1:0]  prio;
    logic [ALARM_W-1:0] alarm;
    logic [SIG_W-1:0]   signals;
    logic [SIG_W-1:0]   blocked;
  } task_entry_t;

  // slot write broadcast to all cells
  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] slot;
    task_entry_t       entry;
  } wr_bus_t;

  typedef enum logic [1:0] {
    TK_SCAN,
    TK_RECHARGE,
    TK_READ
  } tok_kind_t;

  // token walking down the cell chain
  typedef struct packed {
    logic               valid;
    tok_kind_t          kind;
    logic [ALARM_W-1:0] now_time;
    logic [SLOT_W-1:0]  slot;
    logic               found;
    logic [CNT_W-1:0]   best_cnt;
    logic [SLOT_W-1:0]  best_idx;
    logic               ent_present;
    logic [STATE_W-1:0] ent_state;
    logic [CNT_W-1:0]   ent_counter;
    logic [SIG_W-1:0]   ent_signals;
    logic [ALARM_W-1:0] ent_alarm;
  } tok_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WAIT,
    ST_DONE
  } ctrl_state_t;

endpackage

/* rtl/cps_cell.sv */
`timescale 1ns / 1ps
// one task slot cell: holds the slot and updates the passing token
// depends on cps_pkg
module cps_cell #(
  parameter int unsigned IDX = 0
) (
  input  logic             clk,
  input  logic             rst_n,
  input  cps_pkg::wr_bus_t wr,
  input  cps_pkg::tok_t    tok_in,
  output cps_pkg::tok_t    tok_out
);

  localparam bit SCHED_EN    = (IDX != 0);
  localparam bit ADDRESSABLE = (IDX < (1 << cps_pkg::SLOT_W));
  localparam logic [cps_pkg::SLOT_W-1:0] MY_SLOT = cps_pkg::SLOT_W'(IDX);

  cps_pkg::task_entry_t entry_r, entry_nxt;
  cps_pkg::tok_t        tok_r, tok_nxt;

  logic                        alarm_hit;
  logic [cps_pkg::SIG_W-1:0]   sig_upd;
  logic                        wake;
  logic [cps_pkg::CNT_W-1:0]   rech_cnt;
  logic                        cand;
  logic [cps_pkg::CNT_W-1:0]   cand_cnt;

  // per-slot alarm, wake and recharge terms
  always_comb begin
    alarm_hit = (entry_r.alarm != '0) && (entry_r.alarm < tok_in.now_time);
    sig_upd   = entry_r.signals | (alarm_hit ? cps_pkg::SIG_ALRM_BIT : '0);
    wake      = ((sig_upd & ~(cps_pkg::BLOCKABLE_MASK & entry_r.blocked)) != '0) &&
                (entry_r.run_state == cps_pkg::RS_INTERRUPTIBLE);
    rech_cnt  = (entry_r.counter >> 1) + cps_pkg::CNT_W'(entry_r.prio);
  end

  // slot update and token step
  always_comb begin
    entry_nxt = entry_r;
    tok_nxt   = tok_in;
    cand      = 1'b0;
    cand_cnt  = entry_r.counter;
    if (wr.en && ADDRESSABLE && (wr.slot == MY_SLOT)) begin
      entry_nxt = wr.entry;
    end
    if (tok_in.valid) begin
      case (tok_in.kind)
        cps_pkg::TK_SCAN: begin
          if (SCHED_EN && entry_r.present) begin
            if (alarm_hit) begin
              entry_nxt.signals = sig_upd;
              entry_nxt.alarm   = '0;
            end
            if (wake) begin
              entry_nxt.run_state = cps_pkg::RS_RUNNING;
            end
            cand = (entry_nxt.run_state == cps_pkg::RS_RUNNING);
          end
        end
        cps_pkg::TK_RECHARGE: begin
          if (SCHED_EN && entry_r.present) begin
            entry_nxt.counter = rech_cnt;
            cand_cnt          = rech_cnt;
            cand              = (entry_r.run_state == cps_pkg::RS_RUNNING);
          end
        end
        cps_pkg::TK_READ: begin
          if (ADDRESSABLE && (tok_in.slot == MY_SLOT)) begin
            tok_nxt.ent_present = entry_r.present;
            tok_nxt.ent_state   = entry_r.run_state;
            tok_nxt.ent_counter = entry_r.counter;
            tok_nxt.ent_signals = entry_r.signals;
            tok_nxt.ent_alarm   = entry_r.alarm;
          end
        end
        default: begin
        end
      endcase
    end
    // strict compare keeps ties on the higher slot
    if (cand && (!tok_in.found || (cand_cnt > tok_in.best_cnt))) begin
      tok_nxt.found    = 1'b1;
      tok_nxt.best_cnt = cand_cnt;
      tok_nxt.best_idx = MY_SLOT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_r <= '0;
      tok_r   <= '0;
    end else begin
      entry_r <= entry_nxt;
      tok_r   <= tok_nxt;
    end
  end

  assign tok_out = tok_r;

endmodule

/* rtl/cps_ctrl.sv */
`timescale 1ns / 1ps
// op sequencer: launches tokens into the cell chain and holds the result beat
// depends on cps_pkg
module cps_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  cps_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output cps_pkg::out_item_t out_data,
  output cps_pkg::wr_bus_t   wr,
  output cps_pkg::tok_t      seed,
  input  cps_pkg::tok_t      tail
);

  cps_pkg::ctrl_state_t state_r, state_nxt;
  cps_pkg::tok_t        seed_r, seed_nxt;
  cps_pkg::out_item_t   res_r, res_nxt;
  cps_pkg::out_item_t   out_data_r, out_data_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic                 out_load;

  // next state, token launch and result capture
  always_comb begin
    state_nxt = state_r;
    seed_nxt  = '0;
    res_nxt   = res_r;
    wr        = '0;
    in_ready  = 1'b0;
    out_load  = 1'b0;
    unique case (state_r)
      cps_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          case (in_data.op)
            cps_pkg::OP_WRITE: begin
              wr.en              = 1'b1;
              wr.slot            = in_data.slot;
              wr.entry.present   = in_data.present;
              wr.entry.run_state = in_data.run_state;
              wr.entry.counter   = in_data.counter;
              wr.entry.prio      = in_data.priority_req;
              wr.entry.alarm     = in_data.alarm_time;
              wr.entry.signals   = in_data.signals;
              wr.entry.blocked   = in_data.blocked_mask;
              res_nxt            = '0;
              state_nxt          = cps_pkg::ST_DONE;
            end
            cps_pkg::OP_SCHED: begin
              seed_nxt.valid    = 1'b1;
              seed_nxt.kind     = cps_pkg::TK_SCAN;
              seed_nxt.now_time = in_data.now_time;
              state_nxt         = cps_pkg::ST_WAIT;
            end
            cps_pkg::OP_READ: begin
              seed_nxt.valid = 1'b1;
              seed_nxt.kind  = cps_pkg::TK_READ;
              seed_nxt.slot  = in_data.slot;
              state_nxt      = cps_pkg::ST_WAIT;
            end
            default: begin
              res_nxt   = '0;
              state_nxt = cps_pkg::ST_DONE;
            end
          endcase
        end
      end
      cps_pkg::ST_WAIT: begin
        if (tail.valid) begin
          if ((tail.kind == cps_pkg::TK_SCAN) && tail.found && (tail.best_cnt == '0)) begin
            // best runnable counter is zero: recharge and pick again
            seed_nxt.valid = 1'b1;
            seed_nxt.kind  = cps_pkg::TK_RECHARGE;
          end else begin
            res_nxt = '0;
            if (tail.kind == cps_pkg::TK_READ) begin
              res_nxt.entry_present = tail.ent_present;
              res_nxt.entry_state   = tail.ent_state;
              res_nxt.entry_counter = tail.ent_counter;
              res_nxt.entry_signals = tail.ent_signals;
              res_nxt.entry_alarm   = tail.ent_alarm;
            end else begin
              res_nxt.next_task = tail.found ? tail.best_idx : '0;
              res_nxt.recharged = (tail.kind == cps_pkg::TK_RECHARGE);
            end
            state_nxt = cps_pkg::ST_DONE;
          end
        end
      end
      cps_pkg::ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_load  = 1'b1;
          state_nxt = cps_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = cps_pkg::ST_IDLE;
      end
    endcase
  end

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = res_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= cps_pkg::ST_IDLE;
      seed_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      seed_r      <= seed_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  assign seed      = seed_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* rtl/counter_priority_task_scheduler.sv */
`timescale 1ns / 1ps
// top level of the counter priority task scheduler: sequencer plus chain of slot cells
// depends on cps_pkg, cps_ctrl, cps_cell and counter_priority_task_scheduler_assert.svh
//
//   channel   ports                          beat
//   input     in_valid / in_ready / in_data  op, slot, entry fields, now_time
//   result    out_valid / out_ready / out_data  next_task, recharged, entry_*
//
// a token walks the chain from slot NUM_TASKS-1 down to slot 0, one cell a cycle
// write and unused op go straight to the result register; read walks one token through the chain
// schedule walks a scan token, and then a recharge token when counters are recharged
// one beat at a time; a new beat is taken while the last result waits for out_ready
// synchronous active-low reset clears every slot, the sequencer and the chain
`include "counter_priority_task_scheduler_assert.svh"
module counter_priority_task_scheduler #(
  parameter int unsigned NUM_TASKS = cps_pkg::NUM_TASKS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  cps_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output cps_pkg::out_item_t out_data
);

  cps_pkg::wr_bus_t wr;
  cps_pkg::tok_t    tok_w [NUM_TASKS+1];

  logic tail_vld;
  logic tail_rech;
  logic tail_found;
  logic seed_vld;
  logic launch_acc;

  // sequencer
  cps_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .wr        (wr),
    .seed      (tok_w[NUM_TASKS]),
    .tail      (tok_w[0])
  );

  // chain of slot cells, token enters at the top slot
  for (genvar i = 0; i < NUM_TASKS; i++) begin : g_cell
    cps_cell #(
      .IDX (i)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .wr      (wr),
      .tok_in  (tok_w[i+1]),
      .tok_out (tok_w[i])
    );
  end

  // terms for the checks
  assign tail_vld   = tok_w[0].valid;
  assign tail_rech  = tok_w[0].valid && (tok_w[0].kind == cps_pkg::TK_RECHARGE);
  assign tail_found = tok_w[0].found;
  assign seed_vld   = tok_w[NUM_TASKS].valid;
  assign launch_acc = in_valid && in_ready &&
                      ((in_data.op == cps_pkg::OP_SCHED) || (in_data.op == cps_pkg::OP_READ));

  // checks
  `CPS_ASSERT_IMP(a_idle_chain_empty, clk, rst_n, in_ready, !tail_vld, "chain busy while idle")
  `CPS_ASSERT_IMP(a_recharge_finds, clk, rst_n, tail_rech, tail_found, "recharge found no runner")
  `CPS_ASSERT_NXT(a_launch, clk, rst_n, launch_acc, seed_vld, "no token launched")

endmodule

/* bench/tb_counter_priority_task_scheduler.sv */
`timescale 1ns / 1ps
// self-checking bench for the counter priority task scheduler: directed and random beats
// depends on cps_pkg and the counter_priority_task_scheduler rtl; keeps its own task table
module tb_counter_priority_task_scheduler;
  import cps_pkg::*;

  localparam int NUM_SLOTS    = NUM_TASKS_DEF;
  localparam int RANDOM_BEATS = 650;
  localparam int POOL_TOP     = 8;

  localparam logic [OP_W-1:0]    OP_UNUSED          = 2'd3;
  localparam logic [STATE_W-1:0] RS_UNINTERRUPTIBLE = 3'd2;
  localparam logic [STATE_W-1:0] RS_ZOMBIE          = 3'd3;
  localparam logic [STATE_W-1:0] RS_STOPPED         = 3'd4;
  localparam logic [STATE_W-1:0] RS_ODD             = 3'd7;
  localparam logic [ALARM_W-1:0] ALARM_MAX          = 31'h7fff_ffff;
  localparam logic [SIG_W-1:0]   SIG_ALL            = 32'hffff_ffff;

  // shadow task table, expected result beats and their checking
  class task_table_checker;
    task_entry_t slot_tab[NUM_SLOTS];
    out_item_t   pending_results[$];
    int unsigned bad_beats;

    function new();
      foreach (slot_tab[i]) slot_tab[i] = '0;
      bad_beats = 0;
    endfunction

    function int unsigned outstanding();
      return pending_results.size();
    endfunction

    // running present slot with the largest counter, ties to the higher slot
    function logic [SLOT_W-1:0] pick_runner(output int best_cnt);
      logic [SLOT_W-1:0] pick;
      pick = '0;
      best_cnt = -1;
      for (int i = NUM_SLOTS - 1; i > 0; i--) begin
        if (slot_tab[i].present && slot_tab[i].run_state == RS_RUNNING &&
            int'(slot_tab[i].counter) > best_cnt) begin
          best_cnt = int'(slot_tab[i].counter);
          pick = SLOT_W'(i);
        end
      end
      return pick;
    endfunction

    function void decide_next(input logic [ALARM_W-1:0] now,
                              output logic [SLOT_W-1:0] next_slot, output logic rc);
      int best_cnt;
      // alarms and wakeups, slot zero untouched
      for (int i = NUM_SLOTS - 1; i > 0; i--) begin
        if (slot_tab[i].present) begin
          if (slot_tab[i].alarm != '0 && slot_tab[i].alarm < now) begin
            slot_tab[i].signals |= SIG_ALRM_BIT;
            slot_tab[i].alarm = '0;
          end
          if ((slot_tab[i].signals & ~(BLOCKABLE_MASK & slot_tab[i].blocked)) != '0 &&
              slot_tab[i].run_state == RS_INTERRUPTIBLE)
            slot_tab[i].run_state = RS_RUNNING;
        end
      end
      rc = 1'b0;
      next_slot = pick_runner(best_cnt);
      // every runner out of slice: recharge once and pick again
      if (best_cnt == 0) begin
        for (int i = NUM_SLOTS - 1; i > 0; i--) begin
          if (slot_tab[i].present)
            slot_tab[i].counter = CNT_W'((slot_tab[i].counter >> 1) + slot_tab[i].prio);
        end
        rc = 1'b1;
        next_slot = pick_runner(best_cnt);
      end
    endfunction

    function void accept_request(in_item_t req);
      out_item_t res;
      res = '0;
      case (req.op)
        OP_WRITE: begin
          if (int'(req.slot) < NUM_SLOTS) begin
            slot_tab[req.slot].present   = req.present;
            slot_tab[req.slot].run_state = req.run_state;
            slot_tab[req.slot].counter   = req.counter;
            slot_tab[req.slot].prio      = req.priority_req;
            slot_tab[req.slot].alarm     = req.alarm_time;
            slot_tab[req.slot].signals   = req.signals;
            slot_tab[req.slot].blocked   = req.blocked_mask;
          end
        end
        OP_SCHED: decide_next(req.now_time, res.next_task, res.recharged);
        OP_READ: begin
          if (int'(req.slot) < NUM_SLOTS) begin
            res.entry_present = slot_tab[req.slot].present;
            res.entry_state   = slot_tab[req.slot].run_state;
            res.entry_counter = slot_tab[req.slot].counter;
            res.entry_signals = slot_tab[req.slot].signals;
            res.entry_alarm   = slot_tab[req.slot].alarm;
          end
        end
        default: ;
      endcase
      pending_results.push_back(res);
    endfunction

    function void check_beat(out_item_t got);
      out_item_t want;
      if (pending_results.size() == 0) begin
        bad_beats++;
        if (bad_beats <= 10)
          $display("%0t: result beat with nothing expected: %h", $time, got);
        return;
      end
      want = pending_results.pop_front();
      if (got.next_task != want.next_task || got.recharged != want.recharged ||
          got.entry_present != want.entry_present || got.entry_state != want.entry_state ||
          got.entry_counter != want.entry_counter ||
          got.entry_signals != want.entry_signals || got.entry_alarm != want.entry_alarm) begin
        bad_beats++;
        if (bad_beats <= 10) begin
          $display("%0t: result mismatch", $time);
          $display("  expected next=%0d rc=%0b pres=%0b st=%0d cnt=%0d sig=%h alarm=%h",
                   want.next_task, want.recharged, want.entry_present, want.entry_state,
                   want.entry_counter, want.entry_signals, want.entry_alarm);
          $display("  actual   next=%0d rc=%0b pres=%0b st=%0d cnt=%0d sig=%h alarm=%h",
                   got.next_task, got.recharged, got.entry_present, got.entry_state,
                   got.entry_counter, got.entry_signals, got.entry_alarm);
        end
      end
    endfunction
  endclass

  logic      clk;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  task_table_checker   sb;
  int unsigned         beats_sent = 0;
  bit                  no_gaps    = 1'b0;
  logic [ALARM_W-1:0]  cur_now    = '0;

  // scratch beat for scenarios that tweak a random write
  in_item_t in_data_tmp;

  counter_priority_task_scheduler #(.NUM_TASKS(NUM_SLOTS)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // hard limit on the run
  initial begin
    #20_000_000;
    $display("FAIL");
    $finish;
  end

  // sender gap: mostly none or short, a few long
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // beat with every field random, then the op forced
  function automatic in_item_t noise_item(logic [OP_W-1:0] op);
    logic [159:0] raw;
    in_item_t     it;
    raw = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom()};
    it = raw[$bits(in_item_t)-1:0];
    it.op = op;
    return it;
  endfunction

  function automatic in_item_t slot_write(int slot, bit present, logic [STATE_W-1:0] state,
                                          int cnt, int prio, logic [ALARM_W-1:0] alarm,
                                          logic [SIG_W-1:0] sig, logic [SIG_W-1:0] blk);
    in_item_t it;
    it = noise_item(OP_WRITE);
    it.slot         = SLOT_W'(slot);
    it.present      = present;
    it.run_state    = state;
    it.counter      = CNT_W'(cnt);
    it.priority_req = PRIO_W'(prio);
    it.alarm_time   = alarm;
    it.signals      = sig;
    it.blocked_mask = blk;
    return it;
  endfunction

  function automatic in_item_t sched_item(logic [ALARM_W-1:0] now);
    in_item_t it;
    it = noise_item(OP_SCHED);
    it.now_time = now;
    return it;
  endfunction

  function automatic in_item_t read_item(int slot);
    in_item_t it;
    it = noise_item(OP_READ);
    it.slot = SLOT_W'(slot);
    return it;
  endfunction

  // signal set: empty, one special signal, one random signal, or anything
  function automatic logic [SIG_W-1:0] rand_sigs();
    case ($urandom_range(0, 6))
      0, 1: return '0;
      2: return SIG_KILL_BIT;
      3: return SIG_STOP_BIT;
      4: return SIG_ALRM_BIT;
      5: return SIG_W'(1) << $urandom_range(0, 31);
      default: return $urandom();
    endcase
  endfunction

  function automatic in_item_t rand_write(int slot);
    int unsigned        r;
    logic [STATE_W-1:0] state;
    int                 cnt;
    int                 prio;
    logic [ALARM_W-1:0] alarm;
    logic [SIG_W-1:0]   blk;
    r = $urandom_range(0, 9);
    state = (r < 4) ? RS_RUNNING : (r < 7) ? RS_INTERRUPTIBLE : STATE_W'($urandom_range(2, 7));
    r = $urandom_range(0, 2);
    cnt = (r == 0) ? 0 : (r == 1) ? $urandom_range(0, 15) : $urandom_range(0, 511);
    prio = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 255);
    r = $urandom_range(0, 2);
    alarm = (r == 0) ? '0 :
            (r == 1) ? ALARM_W'(cur_now + $urandom_range(0, 20) - 10) : ALARM_W'($urandom());
    r = $urandom_range(0, 3);
    blk = (r == 0) ? '0 : (r == 1) ? SIG_ALL : (r == 2) ? rand_sigs() : $urandom();
    return slot_write(slot, $urandom_range(0, 9) != 0, state, cnt, prio, alarm,
                      rand_sigs(), blk);
  endfunction

  // schedule tick: mostly creeping forward, sometimes a jump anywhere
  function automatic logic [ALARM_W-1:0] next_now();
    if ($urandom_range(0, 9) == 0) cur_now = ALARM_W'($urandom());
    else cur_now = ALARM_W'(cur_now + $urandom_range(0, 12));
    return cur_now;
  endfunction

  function automatic int pool_slot();
    return ($urandom_range(0, 11) == 0) ? 0 : $urandom_range(1, POOL_TOP);
  endfunction

  // one input beat: optional gap, then hold valid until accepted
  task automatic send_beat(input in_item_t it);
    int unsigned gap;
    gap = idle_len();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.accept_request(it);
    beats_sent++;
  endtask

  // hold off the sender until every expected beat has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.outstanding() != 0);
  endtask

  // result side back-pressure
  initial begin
    int unsigned mode;
    @(posedge clk);
    forever begin
      mode = $urandom_range(0, 9);
      if (mode < 3) begin
        out_ready <= 1'b1;
        repeat ($urandom_range(10, 60)) @(posedge clk);
      end else if (mode < 9) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk);
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 4)) @(posedge clk);
      end else begin
        out_ready <= 1'b0;
        repeat ($urandom_range(20, 60)) @(posedge clk);
        out_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // result monitor
  initial begin
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) sb.check_beat(out_data);
    end
  end

  // stimulus
  initial begin
    int unsigned base;
    int unsigned kind;
    int          s;
    bit          drained_once;
    drained_once = 1'b0;
    sb = new();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty table, unused op, slot zero extremes
    send_beat(read_item(NUM_SLOTS - 1));
    send_beat(noise_item(OP_UNUSED));
    send_beat(sched_item('0));
    send_beat(slot_write(0, 1'b1, RS_RUNNING, 511, 255, ALARM_MAX, SIG_ALL, SIG_ALL));
    send_beat(read_item(0));
    // zero priority: recharge leaves counters at zero, highest runner wins
    send_beat(slot_write(63, 1'b1, RS_RUNNING, 0, 0, '0, '0, '0));
    send_beat(slot_write(62, 1'b1, RS_RUNNING, 0, 0, '0, '0, '0));
    send_beat(sched_item(31'd5));
    // wakeups: kill and stop ignore the mask, blocked signals do not wake
    send_beat(slot_write(1, 1'b1, RS_RUNNING, 511, 255, 31'd100, '0, '0));
    send_beat(slot_write(2, 1'b1, RS_INTERRUPTIBLE, 300, 1, '0, SIG_KILL_BIT, SIG_ALL));
    send_beat(slot_write(3, 1'b1, RS_INTERRUPTIBLE, 400, 2, '0, 32'h10, 32'h10));
    send_beat(slot_write(4, 1'b1, RS_INTERRUPTIBLE, 450, 3, 31'd100, '0, '0));
    send_beat(slot_write(5, 1'b1, RS_ODD, 500, 4, '0, SIG_KILL_BIT, '0));
    send_beat(slot_write(6, 1'b1, RS_INTERRUPTIBLE, 350, 5, '0, SIG_STOP_BIT, SIG_ALL));
    // alarm equal to now does not fire, one tick later it does
    send_beat(sched_item(31'd100));
    send_beat(read_item(4));
    send_beat(sched_item(31'd101));
    send_beat(read_item(4));
    send_beat(read_item(1));
    send_beat(slot_write(1, 1'b0, RS_RUNNING, 0, 0, '0, '0, '0));
    send_beat(sched_item(ALARM_MAX));
    // equal counters: higher slot wins
    send_beat(slot_write(3, 1'b1, RS_INTERRUPTIBLE, 450, 6, '0, SIG_ALRM_BIT, SIG_ALRM_BIT));
    send_beat(slot_write(40, 1'b1, RS_RUNNING, 450, 7, '0, '0, '0));
    send_beat(sched_item(ALARM_MAX));
    send_beat(read_item(5));

    // random scenarios over a small pool of slots plus excursions
    base = beats_sent;
    while (beats_sent - base < RANDOM_BEATS) begin
      no_gaps = ($urandom_range(0, 3) == 0);
      kind = $urandom_range(0, 99);
      if (kind < 45) begin
        // pool burst: writes, schedules, reads
        repeat ($urandom_range(1, 6)) send_beat(rand_write(pool_slot()));
        repeat ($urandom_range(1, 2)) send_beat(sched_item(next_now()));
        repeat ($urandom_range(0, 2)) send_beat(read_item(pool_slot()));
      end else if (kind < 60) begin
        // every running pool slot out of slice; the schedule recharges if no other runner has slice left
        for (s = 1; s <= POOL_TOP; s++) begin
          in_data_tmp = rand_write(s);
          if (in_data_tmp.run_state == RS_RUNNING) in_data_tmp.counter = '0;
          send_beat(in_data_tmp);
        end
        send_beat(sched_item(next_now()));
        repeat (2) send_beat(read_item(pool_slot()));
      end else if (kind < 75) begin
        // excursion to any slot, retired again afterwards
        s = $urandom_range(0, NUM_SLOTS - 1);
        send_beat(rand_write(s));
        send_beat(sched_item(next_now()));
        send_beat(read_item(s));
        in_data_tmp = rand_write(s);
        in_data_tmp.present = 1'b0;
        send_beat(in_data_tmp);
      end else if (kind < 90) begin
        repeat ($urandom_range(1, 3)) send_beat(read_item($urandom_range(0, NUM_SLOTS - 1)));
      end else begin
        repeat ($urandom_range(1, 3)) send_beat(noise_item(OP_UNUSED));
      end
      if ((!drained_once && beats_sent - base > RANDOM_BEATS / 2) ||
          $urandom_range(0, 24) == 0) begin
        drain_results();
        drained_once = 1'b1;
      end
    end

    drain_results();
    repeat (2 * NUM_SLOTS + 10) @(posedge clk);
    if (sb.bad_beats == 0 && sb.outstanding() == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
